// ===== rtl/odtd_pkg.sv =====
// Shared constants for the on-demand task dispatcher.
`default_nettype none
package odtd_pkg;

  // Default sizes
  localparam int MAX_WORKERS_DEF = 16;
  localparam int STACK_DEPTH_DEF = 64;
  localparam int TASK_BITS_DEF   = 32;

  // Fixed port widths
  localparam int MODE_W    = 2;
  localparam int TASK_ID_W = 32;
  localparam int WID_W     = 4;
  localparam int ACT_W     = 2;
  localparam int CFG_W     = 5;

  // Event kinds
  localparam logic [MODE_W-1:0] MODE_TASK  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_READY = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

  // Result actions
  localparam logic [ACT_W-1:0] ACT_NONE     = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DISPATCH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_END      = 2'd2;
  localparam logic [ACT_W-1:0] ACT_DROP     = 2'd3;

endpackage
`default_nettype wire

// ===== rtl/odtd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module odtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== rtl/odtd_rr_pick.sv =====
// Rotating priority encoder: first ready worker after the last one chosen.
`default_nettype none
module odtd_rr_pick #(
  parameter int N = 16,
  localparam int IDX_W = (N > 1) ? $clog2(N) : 1
) (
  input  wire logic [N-1:0]     flags,
  input  wire logic [IDX_W-1:0] last,
  output logic                  found,
  output logic      [IDX_W-1:0] idx
);

  logic [N-1:0]     hi;
  logic [IDX_W-1:0] idx_hi;
  logic [IDX_W-1:0] idx_lo;

  always_comb begin
    idx_hi = '0;
    idx_lo = '0;
    for (int i = 0; i < N; i++) begin
      hi[i] = flags[i] && (IDX_W'(i) > last);
    end
    // Scan downwards so the lowest set bit wins.
    for (int i = N - 1; i >= 0; i--) begin
      if (hi[i]) begin
        idx_hi = IDX_W'(i);
      end
      if (flags[i]) begin
        idx_lo = IDX_W'(i);
      end
    end
    found = |flags;
    idx   = (|hi) ? idx_hi : idx_lo;
  end

endmodule
`default_nettype wire

// ===== rtl/on_demand_task_dispatcher.sv =====
// On-demand task dispatcher: hands tasks to ready workers in round-robin order.
// Input channel (in_valid/in_ready) carries events: a new task, a worker
// reporting ready, or end of input. Each event yields exactly one result on
// the output channel (out_valid/out_ready): nothing, dispatch of a task to a
// worker, end broadcast, or a task dropped because the pending stack is full.
// An event transferred at one clock edge sits in the input register and is
// worked on there; its result enters the output register at the edge where that
// register is empty or being read. Throughput is one event per cycle while
// out_ready holds: the whole update is one stage between the input and output
// registers, and the pending stack is one RAM with one write and one registered
// read per cycle, the read always fetching the current top.
// When the receiver stalls, the output register holds its result, the input
// register keeps one more event, and in_ready falls once both are full.
// Reset (synchronous, rst_n low) marks all attached workers ready, empties the
// stack and clears the end mark; writing cfg_data with cfg_we does the same
// with the new worker count (0 counts as 1, values above MAX_WORKERS saturate).
// The stack needs no clearing pass: only entries below the fill count are used.
`default_nettype none
module on_demand_task_dispatcher #(
  parameter int MAX_WORKERS = odtd_pkg::MAX_WORKERS_DEF,
  parameter int STACK_DEPTH = odtd_pkg::STACK_DEPTH_DEF,
  parameter int TASK_BITS   = odtd_pkg::TASK_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [odtd_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [odtd_pkg::MODE_W-1:0]    in_mode,
  input  wire logic [odtd_pkg::TASK_ID_W-1:0] in_task_id,
  input  wire logic [odtd_pkg::WID_W-1:0]     in_worker_id,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic      [odtd_pkg::ACT_W-1:0]     out_action,
  output logic      [odtd_pkg::WID_W-1:0]     out_target_worker,
  output logic      [odtd_pkg::TASK_ID_W-1:0] out_dispatched_task
);

  localparam int IDX_W = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int NW_W  = $clog2(MAX_WORKERS + 1);
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);
  localparam int AW    = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int RST_WORKERS = (MAX_WORKERS < 16) ? MAX_WORKERS : 16;

  // Input register
  logic                           in_valid_r;
  logic [odtd_pkg::MODE_W-1:0]    in_mode_r;
  logic [TASK_BITS-1:0]           in_task_r;
  logic [odtd_pkg::WID_W-1:0]     in_wid_r;

  // Output register
  logic                           out_valid_r;
  logic [odtd_pkg::ACT_W-1:0]     out_action_r;
  logic [odtd_pkg::WID_W-1:0]     out_target_r;
  logic [odtd_pkg::TASK_ID_W-1:0] out_task_r;

  // Dispatch state
  logic [NW_W-1:0]        nwork_r;
  logic [MAX_WORKERS-1:0] flags_r,  flags_nxt;
  logic [NW_W-1:0]        rcount_r, rcount_nxt;
  logic [IDX_W-1:0]       last_r,   last_nxt;
  logic [CNT_W-1:0]       pcount_r, pcount_nxt;
  logic                   ended_r,  ended_nxt;

  // Top-of-stack forwarding for a push and a read of the same entry
  logic                   byp_r;
  logic [TASK_BITS-1:0]   byp_data_r;

  logic                       fire;
  logic                       take;
  logic                       push;
  logic [odtd_pkg::ACT_W-1:0] act;
  logic [odtd_pkg::WID_W-1:0] tgt;
  logic [TASK_BITS-1:0]       snd;
  logic [TASK_BITS-1:0]       tos;
  logic [TASK_BITS-1:0]       ram_rdata;
  logic [AW-1:0]              raddr;
  logic                       pick_found;
  logic [IDX_W-1:0]           pick_idx;
  logic                       wid_ok;
  logic [IDX_W-1:0]           widx;
  logic [NW_W-1:0]            cfg_n;
  logic [NW_W-1:0]            n_load;
  logic [MAX_WORKERS-1:0]     flags_load;

  assign fire      = in_valid_r && (!out_valid_r || out_ready);
  assign take      = in_valid && in_ready;
  assign in_ready  = !in_valid_r || fire;
  assign out_valid = out_valid_r;
  assign out_action          = out_action_r;
  assign out_target_worker   = out_target_r;
  assign out_dispatched_task = out_task_r;

  odtd_rr_pick #(
    .N (MAX_WORKERS)
  ) u_pick (
    .flags (flags_r),
    .last  (last_r),
    .found (pick_found),
    .idx   (pick_idx)
  );

  odtd_ram #(
    .WIDTH (TASK_BITS),
    .DEPTH (STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (push),
    .waddr (AW'(pcount_r)),
    .wdata (in_task_r),
    .raddr (raddr),
    .rdata (ram_rdata)
  );

  // The read always targets the entry that will be on top after this edge.
  assign raddr = (pcount_nxt == '0) ? '0 : AW'(pcount_nxt - CNT_W'(1));
  assign tos   = byp_r ? byp_data_r : ram_rdata;

  assign wid_ok = 32'(in_wid_r) < 32'(nwork_r);
  assign widx   = IDX_W'(in_wid_r);

  always_comb begin
    flags_nxt  = flags_r;
    rcount_nxt = rcount_r;
    last_nxt   = last_r;
    pcount_nxt = pcount_r;
    ended_nxt  = ended_r;
    push       = 1'b0;
    act        = odtd_pkg::ACT_NONE;
    tgt        = '0;
    snd        = '0;
    if (fire) begin
      case (in_mode_r)
        odtd_pkg::MODE_TASK: begin
          if (pick_found) begin
            flags_nxt[pick_idx] = 1'b0;
            rcount_nxt = rcount_r - NW_W'(1);
            last_nxt   = pick_idx;
            act        = odtd_pkg::ACT_DISPATCH;
            tgt        = odtd_pkg::WID_W'(pick_idx);
            snd        = in_task_r;
          end else if (pcount_r < CNT_W'(STACK_DEPTH)) begin
            push       = 1'b1;
            pcount_nxt = pcount_r + CNT_W'(1);
          end else begin
            act = odtd_pkg::ACT_DROP;
            snd = in_task_r;
          end
        end
        odtd_pkg::MODE_READY: begin
          if (wid_ok && !flags_r[widx]) begin
            if (pcount_r != '0) begin
              pcount_nxt = pcount_r - CNT_W'(1);
              act        = odtd_pkg::ACT_DISPATCH;
              tgt        = in_wid_r;
              snd        = tos;
            end else begin
              flags_nxt[widx] = 1'b1;
              rcount_nxt      = rcount_r + NW_W'(1);
              if (ended_r && (rcount_nxt == nwork_r)) begin
                act = odtd_pkg::ACT_END;
              end
            end
          end
        end
        odtd_pkg::MODE_END: begin
          ended_nxt = 1'b1;
          if ((rcount_r == nwork_r) && (pcount_r == '0)) begin
            act = odtd_pkg::ACT_END;
          end
        end
        default: begin
          act = odtd_pkg::ACT_NONE;
        end
      endcase
    end
  end

  // Worker count and ready flags loaded at reset or by a register write.
  always_comb begin
    if (cfg_data == '0) begin
      cfg_n = NW_W'(1);
    end else if (32'(cfg_data) > 32'(MAX_WORKERS)) begin
      cfg_n = NW_W'(MAX_WORKERS);
    end else begin
      cfg_n = NW_W'(cfg_data);
    end
    n_load = rst_n ? cfg_n : NW_W'(RST_WORKERS);
    for (int i = 0; i < MAX_WORKERS; i++) begin
      flags_load[i] = NW_W'(i) < n_load;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_we) begin
      nwork_r  <= n_load;
      flags_r  <= flags_load;
      rcount_r <= n_load;
      last_r   <= IDX_W'(n_load - NW_W'(1));
      pcount_r <= '0;
      ended_r  <= 1'b0;
    end else begin
      flags_r  <= flags_nxt;
      rcount_r <= rcount_nxt;
      last_r   <= last_nxt;
      pcount_r <= pcount_nxt;
      ended_r  <= ended_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      byp_r       <= 1'b0;
    end else begin
      if (take) begin
        in_valid_r <= 1'b1;
      end else if (fire) begin
        in_valid_r <= 1'b0;
      end
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      byp_r <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      in_mode_r <= in_mode;
      in_task_r <= TASK_BITS'(in_task_id);
      in_wid_r  <= in_worker_id;
    end
    if (fire) begin
      out_action_r <= act;
      out_target_r <= tgt;
      out_task_r   <= odtd_pkg::TASK_ID_W'(snd);
    end
    if (push) begin
      byp_data_r <= in_task_r;
    end
  end

  // The ready count tracks the flags exactly.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    32'(rcount_r) == 32'($countones(flags_r)))
    else $error("ready count differs from ready flags");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    rcount_r <= nwork_r)
    else $error("more ready workers than attached");

  a_flags_attached: assert property (@(posedge clk) disable iff (!rst_n)
    (flags_r >> nwork_r) == '0)
    else $error("ready flag set for a worker outside the attached range");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(pcount_r) <= 32'(STACK_DEPTH))
    else $error("pending count beyond stack depth");

  a_end_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !cfg_we && (act == odtd_pkg::ACT_END))
      |=> (pcount_r == '0) && (rcount_r == nwork_r))
    else $error("end reported while work remains");

endmodule
`default_nettype wire
